### src/tabulated_linear_interpolator_macros.svh
// Assertion macros shared by the interpolator RTL.
`ifndef TABULATED_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABULATED_LINEAR_INTERPOLATOR_MACROS_SVH

// Condition and consequence in the same cycle.
`define TLI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence in the cycle after the condition.
`define TLI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/tli_pkg.sv
package tli_pkg;

   localparam int TableDepth = 1024;
   localparam int IdxW       = 10;
   localparam int SizeW      = 11;
   localparam int DataW      = 32;
   localparam int MapW       = 49;
   localparam int DiffW      = 50;
   localparam int ProdW      = 82;
   localparam int QuotW      = 40;
   localparam int MulW       = 34;

   typedef enum logic [1:0] {
      CSR_SCALING    = 2'd0,
      CSR_X_SHIFT    = 2'd1,
      CSR_X_SCALE    = 2'd2,
      CSR_TABLE_SIZE = 2'd3
   } csr_idx_type;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_READ  = 13'b0000000000010,
      S_MULT  = 13'b0000000000100,
      S_MAP   = 13'b0000000001000,
      S_PREP  = 13'b0000000010000,
      S_MLO   = 13'b0000000100000,
      S_MHI   = 13'b0000001000000,
      S_ACC   = 13'b0000010000000,
      S_DCHK  = 13'b0000100000000,
      S_DIV   = 13'b0001000000000,
      S_ORD   = 13'b0010000000000,
      S_SCALE = 13'b0100000000000,
      S_RES   = 13'b1000000000000
   } state_type;

   // Saturates a signed 48-bit value to signed 32 bits.
   function automatic logic signed [DataW-1:0] sat32(input logic signed [47:0] v);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = 48'sh0000_7FFF_FFFF;
      lo = -hi - 48'sd1;
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[DataW-1:0];
      end
   endfunction

endpackage

### src/tabulated_linear_interpolator.sv
// Channel   | Ports                                   | Direction | Handshake
// ----------+-----------------------------------------+-----------+------------------------
// request   | start, busy, req_*                      | in        | start high, busy low
// response  | rsp_strobe, rsp_value, rsp_in_domain,   | out       | one-cycle strobe
//           | rsp_last                                |           |
// registers | csr_valid, csr_ready, csr_index,        | in        | valid and ready high
//           | csr_data                                |           |
//
// A load beat writes both tables; a query on an empty table answers in the next cycle.
// Other queries pass read, multiply and map for each table point walked, then scale
// and result; interpolating adds the previous point, two partial products and a
// 40-step divider. The walk, the partial products and the scaling share one 34 x 34 multiplier.
// Reset (synchronous) clears the sequencer, walk pointer and registers; the tables
// are not cleared. The receiver cannot stall, so a result is shown for one cycle.
`include "tabulated_linear_interpolator_macros.svh"

module tabulated_linear_interpolator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [tli_pkg::IdxW-1:0]            req_entry_index,
   input  logic signed [tli_pkg::DataW-1:0]    req_entry_x,
   input  logic signed [tli_pkg::DataW-1:0]    req_entry_y,
   input  logic signed [tli_pkg::DataW-1:0]    req_query_x,
   input  logic                                req_last_of_batch,
   output logic                                rsp_strobe,
   output logic signed [tli_pkg::DataW-1:0]    rsp_value,
   output logic                                rsp_in_domain,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  tli_pkg::csr_idx_type                csr_index,
   input  logic [tli_pkg::DataW-1:0]           csr_data
);
   import tli_pkg::*;

   // Table storage: one write port for loads, one registered read port each.
   logic [DataW-1:0] point_x [TableDepth];
   logic [DataW-1:0] point_y [TableDepth];
   logic signed [DataW-1:0] mem_x_ff;
   logic signed [DataW-1:0] mem_y_ff;

   // Configuration registers.
   logic signed [DataW-1:0] scaling_ff;
   logic signed [DataW-1:0] x_shift_ff;
   logic [30:0]             x_scale_ff;
   logic [SizeW-1:0]        table_size_ff;

   // Sequencer and walk state.
   state_type               state_ff;
   state_type               state_in;
   logic [IdxW-1:0]         walk_ff;
   logic [IdxW-1:0]         j_ff;
   logic [IdxW-1:0]         ptr_ff;
   logic [IdxW-1:0]         nlast_ff;
   logic                    prev_ff;
   logic                    last_ff;
   logic signed [DataW-1:0] xi_ff;

   // Interpolation datapath.
   logic signed [MapW-1:0]  x1_ff;
   logic signed [DataW-1:0] y1_ff;
   logic signed [DataW-1:0] y0_ff;
   logic signed [DataW:0]   dy_ff;
   logic signed [DiffW-1:0] dx_ff;
   logic signed [DiffW-1:0] den_ff;
   logic [DataW:0]          ady_ff;
   logic [MapW-1:0]         adx_ff;
   logic [MapW-1:0]         aden_ff;
   logic                    neg_ff;
   logic [ProdW-1:0]        acc_ff;
   logic [MapW-1:0]         rem_ff;
   logic [QuotW-1:0]        lo_ff;
   logic [QuotW-1:0]        quot_ff;
   logic [5:0]              cnt_ff;
   logic signed [DataW-1:0] ord_ff;

   // Shared multiplier with a registered product.
   logic signed [MulW-1:0]   mul_a;
   logic signed [MulW-1:0]   mul_b;
   logic signed [2*MulW-1:0] mul_ff;

   // Result register.
   logic                    rsp_strobe_ff;
   logic signed [DataW-1:0] rsp_value_ff;
   logic                    rsp_in_domain_ff;
   logic                    rsp_last_ff;

   logic                    accept;
   logic [SizeW-1:0]        n_use;
   logic signed [MapW-1:0]  map_c;
   logic signed [MapW-1:0]  xi_ext;
   logic [MapW:0]           rem2;
   logic                    qbit;
   logic signed [41:0]      ord_sum;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;

   assign n_use  = (table_size_ff > SizeW'(TableDepth)) ? SizeW'(TableDepth) : table_size_ff;
   assign xi_ext = MapW'(xi_ff);
   // Mapped abscissa: floor(x * x_scale / 2^16) + x_shift; the arithmetic shift floors.
   assign map_c  = MapW'($signed(mul_ff[62:16])) + MapW'(x_shift_ff);

   // One long-division step brings in the next dividend bit.
   assign rem2 = {rem_ff, lo_ff[QuotW-1]};
   assign qbit = (rem2 >= {1'b0, aden_ff});

   assign ord_sum = neg_ff ? (42'(y0_ff) - $signed({2'b00, quot_ff}))
                           : (42'(y0_ff) + $signed({2'b00, quot_ff}));

   always_comb begin
      unique case (state_ff)
         S_MULT: begin
            mul_a = MulW'(mem_x_ff);
            mul_b = $signed({3'b000, x_scale_ff});
         end
         S_MLO: begin
            mul_a = $signed({1'b0, ady_ff});
            mul_b = $signed({9'd0, adx_ff[24:0]});
         end
         S_MHI: begin
            mul_a = $signed({1'b0, ady_ff});
            mul_b = $signed({10'd0, adx_ff[48:25]});
         end
         S_SCALE: begin
            mul_a = MulW'(ord_ff);
            mul_b = MulW'(scaling_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff   <= mul_a * mul_b;
      mem_x_ff <= point_x[ptr_ff];
      mem_y_ff <= point_y[ptr_ff];
      if (accept && !req_kind) begin
         point_x[req_entry_index] <= req_entry_x;
         point_y[req_entry_index] <= req_entry_y;
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_kind && n_use != '0) begin
               state_in = S_READ;
            end
         end
         S_READ:  state_in = S_MULT;
         S_MULT:  state_in = S_MAP;
         S_MAP: begin
            if (prev_ff) begin
               state_in = S_PREP;
            end else if (j_ff != nlast_ff && xi_ext > map_c) begin
               state_in = S_READ;
            end else if (xi_ext == map_c) begin
               state_in = S_SCALE;
            end else if (xi_ext < map_c && j_ff != '0) begin
               state_in = S_READ;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PREP: begin
            if (dy_ff == '0 || dx_ff == '0 || den_ff == '0) begin
               state_in = S_SCALE;
            end else begin
               state_in = S_MLO;
            end
         end
         S_MLO:   state_in = S_MHI;
         S_MHI:   state_in = S_ACC;
         S_ACC:   state_in = S_DCHK;
         S_DCHK: begin
            if ({7'd0, acc_ff[ProdW-1:QuotW]} >= aden_ff) begin
               state_in = S_SCALE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (cnt_ff == 6'd1) begin
               state_in = S_ORD;
            end
         end
         S_ORD:   state_in = S_SCALE;
         S_SCALE: state_in = S_RES;
         S_RES:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         walk_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         scaling_ff    <= 32'sd65536;
         x_shift_ff    <= '0;
         x_scale_ff    <= 31'd65536;
         table_size_ff <= '0;
         ptr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= 1'b0;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SCALING:    scaling_ff    <= csr_data;
               CSR_X_SHIFT:    x_shift_ff    <= csr_data;
               CSR_X_SCALE:    x_scale_ff    <= csr_data[30:0];
               CSR_TABLE_SIZE: table_size_ff <= csr_data[SizeW-1:0];
               default:        ;
            endcase
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept && req_kind) begin
                  xi_ff   <= req_query_x;
                  last_ff <= req_last_of_batch;
                  prev_ff <= 1'b0;
                  if (n_use == '0) begin
                     // Empty table: answer at once with a zero outside the domain.
                     rsp_strobe_ff    <= 1'b1;
                     rsp_value_ff     <= '0;
                     rsp_in_domain_ff <= 1'b0;
                     rsp_last_ff      <= req_last_of_batch;
                     walk_ff          <= '0;
                  end else begin
                     nlast_ff <= IdxW'(n_use - 1'b1);
                     // A stale pointer restarts the walk from the first point.
                     if ({1'b0, walk_ff} < n_use) begin
                        j_ff   <= walk_ff;
                        ptr_ff <= walk_ff;
                     end else begin
                        j_ff   <= '0;
                        ptr_ff <= '0;
                     end
                  end
               end
            end
            S_MAP: begin
               if (prev_ff) begin
                  y0_ff  <= mem_y_ff;
                  dy_ff  <= (DataW+1)'(y1_ff) - (DataW+1)'(mem_y_ff);
                  dx_ff  <= DiffW'(xi_ext) - DiffW'(map_c);
                  den_ff <= DiffW'(x1_ff) - DiffW'(map_c);
               end else if (j_ff != nlast_ff && xi_ext > map_c) begin
                  j_ff   <= j_ff + 1'b1;
                  ptr_ff <= j_ff + 1'b1;
               end else begin
                  x1_ff <= map_c;
                  y1_ff <= mem_y_ff;
                  if (xi_ext == map_c) begin
                     ord_ff <= mem_y_ff;
                  end else if (xi_ext < map_c && j_ff != '0) begin
                     prev_ff <= 1'b1;
                     ptr_ff  <= j_ff - 1'b1;
                  end else begin
                     // Outside the mapped range.
                     rsp_strobe_ff    <= 1'b1;
                     rsp_value_ff     <= '0;
                     rsp_in_domain_ff <= 1'b0;
                     rsp_last_ff      <= last_ff;
                     walk_ff          <= last_ff ? '0 : j_ff;
                  end
               end
            end
            S_PREP: begin
               ord_ff  <= y0_ff;
               ady_ff  <= dy_ff[DataW] ? (DataW+1)'(-dy_ff) : dy_ff;
               adx_ff  <= dx_ff[DiffW-1] ? MapW'(-dx_ff) : MapW'(dx_ff);
               aden_ff <= den_ff[DiffW-1] ? MapW'(-den_ff) : MapW'(den_ff);
               neg_ff  <= dy_ff[DataW] ^ dx_ff[DiffW-1] ^ den_ff[DiffW-1];
            end
            // The accumulator takes the low partial product first, then adds the high one.
            S_MHI: begin
               acc_ff <= {24'd0, mul_ff[57:0]};
            end
            S_ACC: begin
               acc_ff <= acc_ff + {mul_ff[56:0], 25'd0};
            end
            S_DCHK: begin
               if ({7'd0, acc_ff[ProdW-1:QuotW]} >= aden_ff) begin
                  // Quotient would reach 2^40: the ordinate saturates.
                  ord_ff <= neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
               end else begin
                  rem_ff  <= {7'd0, acc_ff[ProdW-1:QuotW]};
                  lo_ff   <= acc_ff[QuotW-1:0];
                  quot_ff <= '0;
                  cnt_ff  <= 6'(QuotW);
               end
            end
            S_DIV: begin
               rem_ff  <= qbit ? MapW'(rem2 - {1'b0, aden_ff}) : rem2[MapW-1:0];
               lo_ff   <= {lo_ff[QuotW-2:0], 1'b0};
               quot_ff <= {quot_ff[QuotW-2:0], qbit};
               cnt_ff  <= cnt_ff - 1'b1;
            end
            S_ORD: begin
               ord_ff <= sat32(48'(ord_sum));
            end
            S_RES: begin
               rsp_strobe_ff    <= 1'b1;
               rsp_value_ff     <= sat32(mul_ff[63:16]);
               rsp_in_domain_ff <= 1'b1;
               rsp_last_ff      <= last_ff;
               walk_ff          <= last_ff ? '0 : j_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_in_domain = rsp_in_domain_ff;
   assign rsp_last      = rsp_last_ff;

   `TLI_ASSERT_NEXT(a_load_silent, accept && !req_kind, !rsp_strobe,
                    "a load beat produced a result")
   `TLI_ASSERT_NOW(a_out_zero, rsp_strobe && !rsp_in_domain, rsp_value == '0,
                   "out-of-domain result is not zero")
   `TLI_ASSERT_NOW(a_div_count, state_ff == S_DIV, cnt_ff != '0 && cnt_ff <= 6'(QuotW),
                   "divider step count out of range")
   `TLI_ASSERT_NOW(a_walk_bound, state_ff == S_MAP && !prev_ff, j_ff <= nlast_ff,
                   "walk passed the last point in use")

endmodule
